// ===== hdl/sgtd_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding Goertzel tone detector package
// Shared constants, register indexes, command/status types and CORDIC table.
// ----------------------------------------------------------------------------
package sgtd_pkg;

  localparam int MAX_WINDOW_DEF  = 256;
  localparam int MAX_TONES_DEF   = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int ACC_W       = 40;
  localparam int COEF_W      = 16;
  localparam int PROD_W      = ACC_W + COEF_W;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int TONE_IDX_W  = 3;
  localparam int TONE_CNT_W  = 4;
  localparam int WLEN_W      = 9;
  localparam int HOP_W       = 16;
  localparam int POWER_W     = 64;
  localparam int MAG_W       = 32;
  localparam int PHASE_W     = 16;
  localparam int CORDIC_W    = 44;
  localparam int ANGLE_W     = 28;
  localparam int CORDIC_STEPS = 20;
  localparam int ROOT_STEPS   = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TONE_PAIR_01    = 4'd0,
    REG_TONE_PAIR_23    = 4'd1,
    REG_TONE_PAIR_45    = 4'd2,
    REG_TONE_PAIR_67    = 4'd3,
    REG_TONE_COUNT      = 4'd4,
    REG_WINDOW_LENGTH   = 4'd5,
    REG_HOP_LENGTH      = 4'd6,
    REG_POWER_THRESHOLD = 4'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TONE_INIT,
    OP_MUL,
    OP_ACC,
    OP_FIN_MUL,
    OP_FIN_ADD,
    OP_ABS,
    OP_SQ_PART,
    OP_SQ_SUM,
    OP_POWER,
    OP_ROOT_INIT,
    OP_ROOT_STEP,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic                  accept;
    op_t                   op;
    logic [TONE_IDX_W-1:0] tone;
    logic                  last;
  } cmd_t;

  typedef struct packed {
    logic                  start_eval;
    logic [TONE_CNT_W-1:0] tones;
    logic                  walk_last;
    logic                  out_free;
  } status_t;

  // Arctangent of 2^-i in units of 2^-24 turn.
  function automatic logic signed [ANGLE_W-1:0] cordic_angle(input logic [4:0] i);
    logic signed [ANGLE_W-1:0] a;
    unique case (i)
      5'd0:    a = 28'sd2097152;
      5'd1:    a = 28'sd1238022;
      5'd2:    a = 28'sd654136;
      5'd3:    a = 28'sd332050;
      5'd4:    a = 28'sd166669;
      5'd5:    a = 28'sd83416;
      5'd6:    a = 28'sd41718;
      5'd7:    a = 28'sd20860;
      5'd8:    a = 28'sd10430;
      5'd9:    a = 28'sd5215;
      5'd10:   a = 28'sd2608;
      5'd11:   a = 28'sd1304;
      5'd12:   a = 28'sd652;
      5'd13:   a = 28'sd326;
      5'd14:   a = 28'sd163;
      5'd15:   a = 28'sd81;
      5'd16:   a = 28'sd41;
      5'd17:   a = 28'sd20;
      5'd18:   a = 28'sd10;
      5'd19:   a = 28'sd5;
      default: a = 28'sd0;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/sgtd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sliding Goertzel controller
// Sequences the window walk, result math and result hand-off for each tone.
// ----------------------------------------------------------------------------
module sgtd_ctrl import sgtd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_MUL, S_ACC, S_FMUL, S_FADD, S_ABS,
    S_SQP, S_SQS, S_PWR, S_RINIT, S_ROOT, S_EMIT
  } state_t;

  state_t                state_r, state_nxt;
  logic [TONE_IDX_W-1:0] tone_r, tone_nxt;
  logic [4:0]            step_r, step_nxt;
  logic                  last;

  assign in_ready = (state_r == S_IDLE);
  assign last     = ({1'b0, tone_r} + 4'd1) == st.tones;

  always_comb begin
    state_nxt = state_r;
    tone_nxt  = tone_r;
    step_nxt  = step_r;
    cmd.accept = in_valid && (state_r == S_IDLE);
    cmd.tone   = tone_r;
    cmd.last   = last;
    cmd.op     = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && st.start_eval && st.tones != '0) begin
          state_nxt = S_INIT;
          tone_nxt  = '0;
        end
      end
      S_INIT: begin
        cmd.op    = OP_TONE_INIT;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = st.walk_last ? S_FMUL : S_MUL;
      end
      S_FMUL: begin
        cmd.op    = OP_FIN_MUL;
        state_nxt = S_FADD;
      end
      S_FADD: begin
        cmd.op    = OP_FIN_ADD;
        state_nxt = S_ABS;
      end
      S_ABS: begin
        cmd.op    = OP_ABS;
        state_nxt = S_SQP;
      end
      S_SQP: begin
        cmd.op    = OP_SQ_PART;
        state_nxt = S_SQS;
      end
      S_SQS: begin
        cmd.op    = OP_SQ_SUM;
        state_nxt = S_PWR;
      end
      S_PWR: begin
        cmd.op    = OP_POWER;
        state_nxt = S_RINIT;
      end
      S_RINIT: begin
        cmd.op    = OP_ROOT_INIT;
        step_nxt  = '0;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.op   = OP_ROOT_STEP;
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(ROOT_STEPS - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.op = OP_EMIT;
          if (last) begin
            state_nxt = S_IDLE;
          end else begin
            tone_nxt  = tone_r + 3'd1;
            state_nxt = S_INIT;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tone_r  <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      tone_r  <= tone_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ===== hdl/sgtd_dp.sv =====
// ----------------------------------------------------------------------------
// Sliding Goertzel datapath
// Window memory, configuration, recurrence, power, square root and phase.
// ----------------------------------------------------------------------------
module sgtd_dp import sgtd_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int MAX_TONES   = MAX_TONES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmd_t                          cmd,
  output status_t                       st,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [TONE_IDX_W-1:0]         out_tone_index,
  output logic signed [ACC_W-1:0]       out_real_part,
  output logic signed [ACC_W-1:0]       out_imag_part,
  output logic [POWER_W-1:0]            out_power,
  output logic [MAG_W-1:0]              out_magnitude,
  output logic signed [PHASE_W-1:0]     out_phase,
  output logic                          out_detected,
  output logic                          out_last_tone
);

  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = PROD_W + 1;
  localparam int SQ_W  = 2 * ACC_W;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] pair_r [4];
  logic [TONE_CNT_W-1:0] tone_count_r;
  logic [WLEN_W-1:0]     wlen_r;
  logic [HOP_W-1:0]      hop_len_r;
  logic [POWER_W-1:0]    thr_r;

  // Window bookkeeping.
  logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rdata_r;
  logic [PTR_W-1:0]       wp_r, wp_nxt, rd_r;
  logic [CNT_W-1:0]       fill_r, fill_nxt, elem_r, n_eff;
  logic [HOP_W-1:0]       hop_cnt_r;
  logic [HOP_W:0]         hop_inc;
  logic [HOP_W-1:0]       hop_eff;
  logic                   hop_hit, cfg_we;

  // Recurrence and result math.
  logic signed [COEF_W-1:0] c2_r, sn_r;
  logic signed [ACC_W-1:0]  s1_r, s2_r, re_r, im_r;
  logic signed [PROD_W-1:0] prod_r, prod2_r;
  logic signed [SUM_W-1:0]  step_sum, fin_sum;
  logic signed [PROD_W-1:0] im_full;
  logic [ACC_W-1:0]         are_r, aim_r;
  logic [63:0]              ll_re_r, ll_im_r;
  logic [39:0]              hl_re_r, hl_im_r;
  logic [15:0]              hh_re_r, hh_im_r;
  logic [SQ_W-1:0]          sq_re_r, sq_im_r;
  logic [SQ_W:0]            tot;
  logic [POWER_W-1:0]       power_r;
  logic [TONE_CNT_W-1:0]    tones_eff;
  logic [2*CFG_DATA_W/4-1:0] tone_word;

  // Square root unit.
  logic [63:0] sq_v_r, sq_r_r, sq_bit_r, sq_t;

  // Phase unit.
  logic signed [CORDIC_W-1:0] cx_r, cy_r, cdx, cdy;
  logic signed [ANGLE_W-1:0]  cacc_r, ang_rnd;
  logic [4:0]                 cstep_r;
  logic                       czero_r;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid;

  always_comb begin
    if (wlen_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(wlen_r) > MAX_WINDOW) begin
      n_eff = CNT_W'(MAX_WINDOW);
    end else begin
      n_eff = CNT_W'(wlen_r);
    end
  end

  assign hop_eff   = (hop_len_r == '0) ? HOP_W'(1) : hop_len_r;
  assign hop_inc   = {1'b0, hop_cnt_r} + 1'b1;
  assign hop_hit   = hop_inc >= {1'b0, hop_eff};
  assign fill_nxt  = (fill_r < n_eff) ? fill_r + 1'b1 : n_eff;
  assign wp_nxt    = (CNT_W'(wp_r) + 1'b1 >= n_eff) ? '0 : wp_r + 1'b1;
  assign tones_eff = (32'(tone_count_r) > MAX_TONES) ? TONE_CNT_W'(MAX_TONES)
                                                     : tone_count_r;

  assign st.start_eval = hop_hit && (fill_nxt == n_eff);
  assign st.tones      = tones_eff;
  assign st.walk_last  = (elem_r == n_eff - 1'b1);
  assign st.out_free   = !out_valid || out_ready;

  assign tone_word = cmd.tone[0] ? pair_r[cmd.tone[2:1]][63:32]
                                 : pair_r[cmd.tone[2:1]][31:0];

  // One recurrence step: s0 = x + (c2*s1 >> 14) - s2.
  assign step_sum = SUM_W'($signed(rdata_r)) + (SUM_W'(prod_r) >>> 14)
                  - SUM_W'(s2_r);
  assign fin_sum  = SUM_W'(s1_r) - (SUM_W'(prod_r) >>> 15);
  assign im_full  = prod2_r >>> 14;
  assign tot      = {1'b0, sq_re_r} + {1'b0, sq_im_r};
  assign sq_t     = sq_r_r + sq_bit_r;
  assign cdx      = cy_r >>> cstep_r;
  assign cdy      = cx_r >>> cstep_r;
  assign ang_rnd  = cacc_r + 28'sd128;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        pair_r[i] <= '0;
      end
      tone_count_r <= '0;
      wlen_r       <= WLEN_W'(256);
      hop_len_r    <= HOP_W'(1);
      thr_r        <= '0;
      wp_r         <= '0;
      fill_r       <= '0;
      hop_cnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TONE_PAIR_01:    pair_r[0]    <= cfg_data;
          REG_TONE_PAIR_23:    pair_r[1]    <= cfg_data;
          REG_TONE_PAIR_45:    pair_r[2]    <= cfg_data;
          REG_TONE_PAIR_67:    pair_r[3]    <= cfg_data;
          REG_TONE_COUNT:      tone_count_r <= cfg_data[TONE_CNT_W-1:0];
          REG_WINDOW_LENGTH: begin
            wlen_r    <= cfg_data[WLEN_W-1:0];
            wp_r      <= '0;
            fill_r    <= '0;
            hop_cnt_r <= '0;
          end
          REG_HOP_LENGTH:      hop_len_r    <= cfg_data[HOP_W-1:0];
          REG_POWER_THRESHOLD: thr_r        <= cfg_data;
          default: ;
        endcase
      end else if (cmd.accept) begin
        wp_r      <= wp_nxt;
        fill_r    <= fill_nxt;
        hop_cnt_r <= hop_hit ? '0 : hop_inc[HOP_W-1:0];
      end
    end
  end

  // Window memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[wp_r] <= in_sample;
    end
    rdata_r <= mem[rd_r];
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_TONE_INIT: begin
        c2_r   <= tone_word[15:0];
        sn_r   <= tone_word[31:16];
        s1_r   <= '0;
        s2_r   <= '0;
        rd_r   <= wp_r;
        elem_r <= '0;
      end
      OP_MUL: begin
        prod_r <= PROD_W'(c2_r) * PROD_W'(s1_r);
      end
      OP_ACC: begin
        s1_r   <= step_sum[ACC_W-1:0];
        s2_r   <= s1_r;
        rd_r   <= (CNT_W'(rd_r) + 1'b1 >= n_eff) ? '0 : rd_r + 1'b1;
        elem_r <= elem_r + 1'b1;
      end
      OP_FIN_MUL: begin
        prod_r  <= PROD_W'(c2_r) * PROD_W'(s2_r);
        prod2_r <= PROD_W'(sn_r) * PROD_W'(s2_r);
      end
      OP_FIN_ADD: begin
        re_r <= fin_sum[ACC_W-1:0];
        im_r <= im_full[ACC_W-1:0];
      end
      OP_ABS: begin
        are_r <= re_r[ACC_W-1] ? ACC_W'(-re_r) : ACC_W'(re_r);
        aim_r <= im_r[ACC_W-1] ? ACC_W'(-im_r) : ACC_W'(im_r);
      end
      OP_SQ_PART: begin
        ll_re_r <= 64'(are_r[31:0]) * 64'(are_r[31:0]);
        ll_im_r <= 64'(aim_r[31:0]) * 64'(aim_r[31:0]);
        hl_re_r <= 40'(are_r[39:32]) * 40'(are_r[31:0]);
        hl_im_r <= 40'(aim_r[39:32]) * 40'(aim_r[31:0]);
        hh_re_r <= 16'(are_r[39:32]) * 16'(are_r[39:32]);
        hh_im_r <= 16'(aim_r[39:32]) * 16'(aim_r[39:32]);
      end
      OP_SQ_SUM: begin
        sq_re_r <= (SQ_W'(hh_re_r) << 64) + (SQ_W'(hl_re_r) << 33) + SQ_W'(ll_re_r);
        sq_im_r <= (SQ_W'(hh_im_r) << 64) + (SQ_W'(hl_im_r) << 33) + SQ_W'(ll_im_r);
      end
      OP_POWER: begin
        power_r <= tot[SQ_W] ? '1 : tot[SQ_W-1:16];
      end
      OP_ROOT_INIT: begin
        sq_v_r   <= power_r;
        sq_r_r   <= '0;
        sq_bit_r <= 64'd1 << 62;
        cstep_r  <= '0;
        czero_r  <= (re_r == '0) && (im_r == '0);
        if (re_r[ACC_W-1]) begin
          cx_r   <= -CORDIC_W'(re_r);
          cy_r   <= -CORDIC_W'(im_r);
          cacc_r <= 28'sd8388608;
        end else begin
          cx_r   <= CORDIC_W'(re_r);
          cy_r   <= CORDIC_W'(im_r);
          cacc_r <= '0;
        end
      end
      OP_ROOT_STEP: begin
        if (sq_v_r >= sq_t) begin
          sq_v_r <= sq_v_r - sq_t;
          sq_r_r <= (sq_r_r >> 1) + sq_bit_r;
        end else begin
          sq_r_r <= sq_r_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
        if (cstep_r != 5'(CORDIC_STEPS)) begin
          cstep_r <= cstep_r + 5'd1;
          if (cy_r > 0) begin
            cx_r   <= cx_r + cdx;
            cy_r   <= cy_r - cdy;
            cacc_r <= cacc_r + cordic_angle(cstep_r);
          end else begin
            cx_r   <= cx_r - cdx;
            cy_r   <= cy_r + cdy;
            cacc_r <= cacc_r - cordic_angle(cstep_r);
          end
        end
      end
      default: ;
    endcase
  end

  // Result word register; the next tone is computed while this one waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      out_tone_index <= cmd.tone;
      out_real_part  <= re_r;
      out_imag_part  <= im_r;
      out_power      <= power_r;
      out_magnitude  <= sq_r_r[MAG_W-1:0];
      out_phase      <= czero_r ? '0 : ang_rnd[23:8];
      out_detected   <= power_r >= thr_r;
      out_last_tone  <= cmd.last;
    end
  end

endmodule

// ===== hdl/sliding_goertzel_tone_detector_unit.sv =====
// Flow: a sample that ends a hop with a full window starts an evaluation;
// each tone then gets a multiply/accumulate walk over the window memory,
// the result math and a 32-step root, and tone words leave in index order.
// Throughput: one sample per cycle when no evaluation runs; an evaluation
// blocks input until its last tone word enters the result register, which
// can be held up by result-side stalls.
// Reset (rst_n low, synchronous) resets control, counters, config and out_valid.
// ----------------------------------------------------------------------------
// Sliding Goertzel tone detector
// Ring window of samples with per-tone Goertzel evaluation every hop.
// ----------------------------------------------------------------------------
module sliding_goertzel_tone_detector_unit import sgtd_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int MAX_TONES   = MAX_TONES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [TONE_IDX_W-1:0]         out_tone_index,
  output logic signed [ACC_W-1:0]       out_real_part,
  output logic signed [ACC_W-1:0]       out_imag_part,
  output logic [POWER_W-1:0]            out_power,
  output logic [MAG_W-1:0]              out_magnitude,
  output logic signed [PHASE_W-1:0]     out_phase,
  output logic                          out_detected,
  output logic                          out_last_tone
);

  cmd_t    cmd;
  status_t st;

  sgtd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  sgtd_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .MAX_TONES   (MAX_TONES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_sample      (in_sample),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tone_index (out_tone_index),
    .out_real_part  (out_real_part),
    .out_imag_part  (out_imag_part),
    .out_power      (out_power),
    .out_magnitude  (out_magnitude),
    .out_phase      (out_phase),
    .out_detected   (out_detected),
    .out_last_tone  (out_last_tone)
  );

endmodule
